@@ sv/stbs_pkg.sv @@
// Shared widths, codes and helpers for the sorted table binary search block.
package stbs_pkg;

  // Fixed field widths of the item ports.
  localparam int IDX_W    = 10;
  localparam int KEY_IN_W = 16;
  localparam int VAL_W    = 16;

  // Item command codes.
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  // Value returned when no key matches.
  localparam logic [VAL_W-1:0] MISS_VALUE = 16'hFFFF;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [VAL_W-1:0] val_t;

  // True when the inclusive range still spans more than two entries,
  // i.e. hi - lo > 1 with both taken as unsigned numbers.
  function automatic logic range_open(idx_t lo, idx_t hi);
    logic [IDX_W:0] diff;
    diff = {1'b0, hi} - {1'b0, lo};
    return !diff[IDX_W] && (diff[IDX_W-1:1] != '0);
  endfunction

  // Midpoint of two indexes, (lo + hi) >> 1 without overflow.
  function automatic idx_t midpoint(idx_t lo, idx_t hi);
    logic [IDX_W:0] sum;
    sum = {1'b0, lo} + {1'b0, hi};
    return sum[IDX_W:1];
  endfunction

endpackage

@@ sv/stbs_ram.sv @@
// Generic single-port synchronous RAM with a registered read port.
module stbs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write or one read per cycle; read data holds until the next read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ sv/sorted_table_binary_search.sv @@
// Top level of the sorted key/value table with binary search lookups.
//
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+----------------------------------------
//  in_     | input     | in_valid / in_ready  | cmd, entry_index/key/value, search_key,
//          |           |                      | low_bound, high_bound
//  out_    | output    | out_valid/out_ready  | found_value, found (one per lookup)
//
// A write item is accepted and then written to memory. A lookup is accepted,
// then each probe passes an address state and a compare of the registered
// memory read: up to ceil(log2(high - low)) midpoint probes plus the two end
// checks, then the item goes to the output register once that register is free.
// When TABLE_DEPTH is below 1024 and not a power of two, each probe and write
// passes an extra reduction state for the index. No clearing pass follows
// reset; in_ready is high in the idle state, also while a finished item waits
// in the output register.
module sorted_table_binary_search #(
  parameter int TABLE_DEPTH = 1024,
  parameter int KEY_BITS    = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_cmd,
  input  logic [stbs_pkg::IDX_W-1:0]  in_entry_index,
  input  logic [stbs_pkg::KEY_IN_W-1:0] in_entry_key,
  input  logic [stbs_pkg::VAL_W-1:0]  in_entry_value,
  input  logic [stbs_pkg::KEY_IN_W-1:0] in_search_key,
  input  logic [stbs_pkg::IDX_W-1:0]  in_low_bound,
  input  logic [stbs_pkg::IDX_W-1:0]  in_high_bound,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [stbs_pkg::VAL_W-1:0]  out_found_value,
  output logic                        out_found
);

  localparam int AW        = $clog2(TABLE_DEPTH);
  localparam int IDX_RANGE = 1 << stbs_pkg::IDX_W;
  // Index reduction is needed only for a depth that is neither a power of
  // two nor at least as large as the index range.
  localparam bit NEED_MOD  = (TABLE_DEPTH < IDX_RANGE) &&
                             ((TABLE_DEPTH & (TABLE_DEPTH - 1)) != 0);
  localparam int RSHIFT    = 20;
  localparam int unsigned RECIP = ((1 << RSHIFT) + TABLE_DEPTH - 1) / TABLE_DEPTH;

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ADDR = 3'd1;
  localparam logic [2:0] S_RED  = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  // What the current memory access is for.
  localparam logic [1:0] PH_WR  = 2'd0;
  localparam logic [1:0] PH_MID = 2'd1;
  localparam logic [1:0] PH_LO  = 2'd2;
  localparam logic [1:0] PH_HI  = 2'd3;

  logic [2:0]                 state_r, state_nxt;
  logic [1:0]                 phase_r, phase_nxt;
  logic [KEY_BITS-1:0]        key_r, key_nxt;
  stbs_pkg::val_t             wval_r, wval_nxt;
  stbs_pkg::idx_t             lo_r, lo_nxt;
  stbs_pkg::idx_t             hi_r, hi_nxt;
  stbs_pkg::idx_t             widx_r, widx_nxt;
  stbs_pkg::idx_t             idx_r, idx_nxt;
  logic [31:0]                prod_r, prod_nxt;
  stbs_pkg::val_t             res_val_r, res_val_nxt;
  logic                       res_found_r, res_found_nxt;
  logic                       out_valid_r, out_valid_nxt;
  stbs_pkg::val_t             out_found_value_r, out_found_value_nxt;
  logic                       out_found_r, out_found_nxt;

  stbs_pkg::idx_t             pidx;
  logic [31:0]                pidx_ext;
  logic [31:0]                idx_ext;
  logic [31:0]                qd;
  logic [31:0]                rem;
  logic [31:0]                rem_fix;
  logic [AW-1:0]              dir_addr;
  logic [AW-1:0]              red_addr;
  logic [AW-1:0]              ram_addr;
  logic                       ram_we;
  logic                       ram_re;
  logic [KEY_BITS-1:0]        rd_key;
  stbs_pkg::val_t             rd_val;
  logic [KEY_BITS-1:0]        in_key_sel;
  logic                       key_le;
  logic                       key_eq;
  stbs_pkg::idx_t             lo_upd;
  stbs_pkg::idx_t             hi_upd;
  logic                       out_free;

  // Index that the current access probes.
  always_comb begin
    case (phase_r)
      PH_WR:   pidx = widx_r;
      PH_MID:  pidx = stbs_pkg::midpoint(lo_r, hi_r);
      PH_LO:   pidx = lo_r;
      default: pidx = hi_r;
    endcase
  end

  // Direct slot: the low address bits already give the index modulo depth.
  assign pidx_ext = {{(32 - stbs_pkg::IDX_W){1'b0}}, pidx};
  assign dir_addr = pidx_ext[AW-1:0];

  // Reduction by reciprocal multiply: quotient from the registered product,
  // then one compare and subtract to correct the remainder.
  assign idx_ext  = {{(32 - stbs_pkg::IDX_W){1'b0}}, idx_r};
  assign qd       = 32'({{(32 - stbs_pkg::IDX_W){1'b0}}, prod_r[RSHIFT +: stbs_pkg::IDX_W]}
                        * 32'(TABLE_DEPTH));
  assign rem      = idx_ext - qd;
  assign rem_fix  = (rem >= 32'(TABLE_DEPTH)) ? rem - 32'(TABLE_DEPTH) : rem;
  assign red_addr = rem_fix[AW-1:0];

  assign ram_addr = (state_r == S_RED) ? red_addr : dir_addr;

  // Memory access is issued from the address state, or the reduction state.
  always_comb begin
    ram_we = 1'b0;
    ram_re = 1'b0;
    if ((state_r == S_ADDR && !NEED_MOD) || state_r == S_RED) begin
      ram_we = (phase_r == PH_WR);
      ram_re = (phase_r != PH_WR);
    end
  end

  stbs_ram #(
    .WIDTH (KEY_BITS),
    .DEPTH (TABLE_DEPTH)
  ) u_key_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (key_r),
    .rdata (rd_key)
  );

  stbs_ram #(
    .WIDTH (stbs_pkg::VAL_W),
    .DEPTH (TABLE_DEPTH)
  ) u_val_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (wval_r),
    .rdata (rd_val)
  );

  // Key of the incoming item cut or extended to KEY_BITS.
  always_comb begin
    logic [31:0] wide;
    wide = {16'b0, (in_cmd == stbs_pkg::CMD_WRITE) ? in_entry_key : in_search_key};
    in_key_sel = wide[KEY_BITS-1:0];
  end

  // Compare of the probed entry and the bound updates of a midpoint probe.
  assign key_le = (rd_key <= key_r);
  assign key_eq = (rd_key == key_r);
  assign lo_upd = key_le ? idx_r : lo_r;
  assign hi_upd = key_le ? hi_r : idx_r;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE);

  // Sequencer.
  always_comb begin
    state_nxt           = state_r;
    phase_nxt           = phase_r;
    key_nxt             = key_r;
    wval_nxt            = wval_r;
    lo_nxt              = lo_r;
    hi_nxt              = hi_r;
    widx_nxt            = widx_r;
    idx_nxt             = idx_r;
    prod_nxt            = prod_r;
    res_val_nxt         = res_val_r;
    res_found_nxt       = res_found_r;
    out_valid_nxt       = out_valid_r && !out_ready;
    out_found_value_nxt = out_found_value_r;
    out_found_nxt       = out_found_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          key_nxt  = in_key_sel;
          wval_nxt = in_entry_value;
          widx_nxt = in_entry_index;
          lo_nxt   = in_low_bound;
          hi_nxt   = in_high_bound;
          if (in_cmd == stbs_pkg::CMD_WRITE) begin
            phase_nxt = PH_WR;
          end else if (stbs_pkg::range_open(in_low_bound, in_high_bound)) begin
            phase_nxt = PH_MID;
          end else begin
            phase_nxt = PH_LO;
          end
          state_nxt = S_ADDR;
        end
      end
      S_ADDR: begin
        idx_nxt  = pidx;
        prod_nxt = 32'(pidx_ext * 32'(RECIP));
        if (NEED_MOD) begin
          state_nxt = S_RED;
        end else begin
          state_nxt = (phase_r == PH_WR) ? S_IDLE : S_CMP;
        end
      end
      S_RED: begin
        state_nxt = (phase_r == PH_WR) ? S_IDLE : S_CMP;
      end
      S_CMP: begin
        state_nxt = S_ADDR;
        case (phase_r)
          PH_MID: begin
            lo_nxt = lo_upd;
            hi_nxt = hi_upd;
            if (key_eq) begin
              res_val_nxt   = rd_val;
              res_found_nxt = 1'b1;
              state_nxt     = S_DONE;
            end else if (stbs_pkg::range_open(lo_upd, hi_upd)) begin
              phase_nxt = PH_MID;
            end else begin
              phase_nxt = PH_LO;
            end
          end
          PH_LO: begin
            if (key_eq) begin
              res_val_nxt   = rd_val;
              res_found_nxt = 1'b1;
              state_nxt     = S_DONE;
            end else begin
              phase_nxt = PH_HI;
            end
          end
          default: begin
            res_val_nxt   = key_eq ? rd_val : stbs_pkg::MISS_VALUE;
            res_found_nxt = key_eq;
            state_nxt     = S_DONE;
          end
        endcase
      end
      S_DONE: begin
        // Hand the item over once the output register is free.
        if (out_free) begin
          out_valid_nxt       = 1'b1;
          out_found_value_nxt = res_val_r;
          out_found_nxt       = res_found_r;
          state_nxt           = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    phase_r           <= phase_nxt;
    key_r             <= key_nxt;
    wval_r            <= wval_nxt;
    lo_r              <= lo_nxt;
    hi_r              <= hi_nxt;
    widx_r            <= widx_nxt;
    idx_r             <= idx_nxt;
    prod_r            <= prod_nxt;
    res_val_r         <= res_val_nxt;
    res_found_r       <= res_found_nxt;
    out_found_value_r <= out_found_value_nxt;
    out_found_r       <= out_found_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_found_value = out_found_value_r;
  assign out_found       = out_found_r;

endmodule
